>>> hw/rtl/firewall_rule_range_table_core_macros.svh
// Assertion macros shared by the rule table checkers.
`ifndef FIREWALL_RULE_RANGE_TABLE_CORE_MACROS_SVH
`define FIREWALL_RULE_RANGE_TABLE_CORE_MACROS_SVH

// Clocked property, switched off while reset is high.
`define FRRT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is also checked through reset.
`define FRRT_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/frrt_pkg.sv
// Shared types and constants for the firewall rule range table.
package frrt_pkg;

  // Default number of rule slots
  localparam int RULE_SLOTS_DEFAULT = 16;

  // Table entry layout: {port range, addr range, addr hi, addr lo, port hi, port lo}
  localparam int ENTRY_W = 98;

  // Item modes
  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_DEL   = 2'd1;
  localparam logic [1:0] MODE_CHECK = 2'd2;

  // Result codes
  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_INVALID  = 3'd1,
    ST_FULL     = 3'd2,
    ST_DELETED  = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_ACCEPT   = 3'd5,
    ST_REJECT   = 3'd6
  } status_t;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_SCAN
  } ctrl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic bad;
    logic hit;
    logic last;
  } dp_stat_t;

endpackage

>>> hw/rtl/frrt_ctrl.sv
// Controller state machine for the rule table scan.
module frrt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  frrt_pkg::dp_stat_t   stat,
  output frrt_pkg::ctrl_cmd_t  cmd
);

  frrt_pkg::ctrl_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= frrt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b0;
    case (state)
      frrt_pkg::S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = frrt_pkg::S_SCAN;
        end
      end
      frrt_pkg::S_SCAN: begin
        busy     = 1'b1;
        cmd.scan = 1'b1;
        // stop on a bad rule, the first matching slot, or after the last slot
        if (stat.bad || stat.hit || stat.last) begin
          cmd.finish = 1'b1;
          state_next = frrt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = frrt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/frrt_datapath.sv
// Datapath: item registers, rule memory, slot scan and result register.
module frrt_datapath #(
  parameter int RULE_SLOTS = frrt_pkg::RULE_SLOTS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  frrt_pkg::ctrl_cmd_t  cmd,
  output frrt_pkg::dp_stat_t   stat,
  input  logic [1:0]           mode,
  input  logic [31:0]          addr_low,
  input  logic [31:0]          addr_high,
  input  logic                 addr_is_range,
  input  logic [15:0]          port_low,
  input  logic [15:0]          port_high,
  input  logic                 port_is_range,
  output logic                 done,
  output logic [2:0]           status,
  output logic [3:0]           slot_index
);

  localparam int IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RULE_SLOTS - 1);

  // Latched item
  logic [1:0]  q_mode;
  logic [31:0] q_alo, q_ahi;
  logic        q_arng;
  logic [15:0] q_plo, q_phi;
  logic        q_prng;
  logic        q_bad;
  logic        bad_in;

  // Rule storage
  logic [frrt_pkg::ENTRY_W-1:0] mem [RULE_SLOTS];
  logic [RULE_SLOTS-1:0]        valid;

  // Scan pipeline
  logic [IDX_W-1:0]             rd_idx, cmp_idx;
  logic                         rd_live, cmp_vld;
  logic [frrt_pkg::ENTRY_W-1:0] rd_entry;
  logic                         rd_valid;

  // Entry fields
  logic [1:0]  e_rng;
  logic [31:0] e_ahi, e_alo;
  logic [15:0] e_phi, e_plo;
  logic        pok, aok, match, hit, wr_en, clr_en;
  logic [frrt_pkg::ENTRY_W-1:0] new_entry;
  frrt_pkg::status_t res_status;
  logic [IDX_W+3:0] idx_wide;

  // Rule check: mode 3 and non-ascending ranges on add/delete are invalid
  always_comb begin
    bad_in = 1'b0;
    if (mode == frrt_pkg::MODE_ADD || mode == frrt_pkg::MODE_DEL) begin
      bad_in = (addr_is_range && !(addr_high > addr_low)) ||
               (port_is_range && !(port_high > port_low));
    end else if (mode != frrt_pkg::MODE_CHECK) begin
      bad_in = 1'b1;
    end
  end

  // Item capture; high parts are stored as zero without a range
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_mode <= mode;
      q_alo  <= addr_low;
      q_ahi  <= addr_is_range ? addr_high : '0;
      q_arng <= addr_is_range;
      q_plo  <= port_low;
      q_phi  <= port_is_range ? port_high : '0;
      q_prng <= port_is_range;
      q_bad  <= bad_in;
    end
  end

  // Scan counters: read slot rd_idx, compare slot cmp_idx in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx   <= '0;
      cmp_idx  <= '0;
      rd_live  <= 1'b0;
      cmp_vld  <= 1'b0;
      rd_valid <= 1'b0;
    end else if (cmd.load) begin
      rd_idx  <= '0;
      rd_live <= 1'b1;
      cmp_vld <= 1'b0;
    end else if (cmd.scan) begin
      cmp_vld  <= rd_live;
      cmp_idx  <= rd_idx;
      rd_valid <= valid[rd_idx];
      if (rd_live) begin
        rd_live <= (rd_idx != LAST_IDX);
        if (rd_idx != LAST_IDX) begin
          rd_idx <= rd_idx + 1'b1;
        end
      end
    end else begin
      cmp_vld <= 1'b0;
    end
  end

  // Rule memory: one read port for the scan, one write port for add
  always_ff @(posedge clk) begin
    if (cmd.scan && rd_live) begin
      rd_entry <= mem[rd_idx];
    end
    if (wr_en) begin
      mem[cmp_idx] <= new_entry;
    end
  end

  assign new_entry = {q_prng, q_arng, q_ahi, q_alo, q_phi, q_plo};

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[cmp_idx] <= 1'b1;
    end else if (clr_en) begin
      valid[cmp_idx] <= 1'b0;
    end
  end

  // Slot compare
  assign e_rng = rd_entry[97:96];
  assign e_ahi = rd_entry[95:64];
  assign e_alo = rd_entry[63:32];
  assign e_phi = rd_entry[31:16];
  assign e_plo = rd_entry[15:0];

  assign pok = e_rng[1] ? (q_plo >= e_plo && q_plo <= e_phi) : (q_plo == e_plo);
  assign aok = e_rng[0] ? (q_alo >= e_alo && q_alo <= e_ahi) : (q_alo == e_alo);

  always_comb begin
    case (q_mode)
      frrt_pkg::MODE_ADD:   match = !rd_valid;
      frrt_pkg::MODE_DEL:   match = rd_valid && (e_rng == {q_prng, q_arng}) &&
                                    (e_alo == q_alo) && (e_ahi == q_ahi) &&
                                    (e_plo == q_plo) && (e_phi == q_phi);
      frrt_pkg::MODE_CHECK: match = rd_valid && pok && aok;
      default:              match = 1'b0;
    endcase
  end

  assign hit       = cmp_vld && match && !q_bad;
  assign stat.bad  = q_bad;
  assign stat.hit  = hit;
  assign stat.last = cmp_vld && (cmp_idx == LAST_IDX);

  assign wr_en  = cmd.finish && hit && (q_mode == frrt_pkg::MODE_ADD);
  assign clr_en = cmd.finish && hit && (q_mode == frrt_pkg::MODE_DEL);

  // Result code
  always_comb begin
    if (q_bad) begin
      res_status = frrt_pkg::ST_INVALID;
    end else begin
      case (q_mode)
        frrt_pkg::MODE_ADD:   res_status = hit ? frrt_pkg::ST_ADDED   : frrt_pkg::ST_FULL;
        frrt_pkg::MODE_DEL:   res_status = hit ? frrt_pkg::ST_DELETED : frrt_pkg::ST_NOTFOUND;
        frrt_pkg::MODE_CHECK: res_status = hit ? frrt_pkg::ST_ACCEPT  : frrt_pkg::ST_REJECT;
        default:              res_status = frrt_pkg::ST_INVALID;
      endcase
    end
  end

  assign idx_wide = {4'b0000, cmp_idx};

  // Result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status     <= res_status;
      slot_index <= hit ? idx_wide[3:0] : 4'd0;
    end
  end

endmodule

>>> hw/rtl/firewall_rule_range_table_core.sv
// Top level of the firewall rule range table.
// An item (add, delete or check) is taken when start is high and busy is low.
// Every item gives one result: done is high for one cycle with status and
// slot_index, and the receiver cannot stall it. Valid items walk the slots in
// order, one slot per cycle, through the single read port of the rule memory
// and one set of comparators, stopping at the first matching slot or after the
// last slot; an invalid item ends without comparing any slot. A new item may
// be started in the cycle that done is high. Reset clears the valid bits at
// once, so there is no clearing pass.
module firewall_rule_range_table_core #(
  parameter int RULE_SLOTS = frrt_pkg::RULE_SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [31:0] addr_low,
  input  logic [31:0] addr_high,
  input  logic        addr_is_range,
  input  logic [15:0] port_low,
  input  logic [15:0] port_high,
  input  logic        port_is_range,
  output logic        done,
  output logic [2:0]  status,
  output logic [3:0]  slot_index
);

  frrt_pkg::ctrl_cmd_t cmd;
  frrt_pkg::dp_stat_t  stat;

  // Sequencer
  frrt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Table and compare datapath
  frrt_datapath #(
    .RULE_SLOTS (RULE_SLOTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .mode          (mode),
    .addr_low      (addr_low),
    .addr_high     (addr_high),
    .addr_is_range (addr_is_range),
    .port_low      (port_low),
    .port_high     (port_high),
    .port_is_range (port_is_range),
    .done          (done),
    .status        (status),
    .slot_index    (slot_index)
  );

endmodule

>>> hw/rtl/frrt_checker.sv
// Port-level assertion checker for the rule table, with its bind.
`include "firewall_rule_range_table_core_macros.svh"

module frrt_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [2:0] status,
  input logic [3:0] slot_index
);

  logic no_slot;

  // result codes that carry no slot
  assign no_slot = (status == frrt_pkg::ST_INVALID)  || (status == frrt_pkg::ST_FULL) ||
                   (status == frrt_pkg::ST_NOTFOUND) || (status == frrt_pkg::ST_REJECT);

  // a transfer in makes the block busy next cycle
  `FRRT_ASSERT(a_busy_after_start, clk, rst, (start && !busy) |=> busy, "no busy after start")

  // the result is shown once the scan is over
  `FRRT_ASSERT(a_done_idle, clk, rst, done |-> !busy, "done while busy")

  // every item passes through the scan state, so strobes never touch
  `FRRT_ASSERT(a_done_single, clk, rst, done |=> !done, "done held two cycles")

  // results without a slot report slot zero
  `FRRT_ASSERT(a_slot_zero, clk, rst, (done && no_slot) |-> (slot_index == 4'd0), "nonzero slot")

  // reset leaves the block idle
  `FRRT_ASSERT_RST(a_reset_idle, clk, rst |=> (!busy && !done), "not idle after reset")

endmodule

bind firewall_rule_range_table_core frrt_checker u_frrt_checker (.*);
